FILE: design/pkrs_pkg.sv
// Shared types, constants and helpers of the Philox keyed random stream.
// No dependencies; imported by every module of the block.
`default_nettype none

package pkrs_pkg;

    localparam int ROUNDS = 10;
    localparam int RND_W  = $clog2(ROUNDS);

    localparam logic [31:0] PH_M0 = 32'hD2511F53;
    localparam logic [31:0] PH_M1 = 32'hCD9E8D57;
    localparam logic [31:0] PH_W0 = 32'h9E3779B9;
    localparam logic [31:0] PH_W1 = 32'hBB67AE85;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 3;
    localparam int IN_W    = 72;

    typedef logic [3:0][31:0] ctr_t;

    typedef enum logic [1:0] {
        OP_NEXT = 2'd0,
        OP_AT   = 2'd1,
        OP_SEEK = 2'd2
    } opcode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SEED   = 3'd0,
        REG_DOMAIN = 3'd1,
        REG_STABLE = 3'd2,
        REG_OCCUR  = 3'd3,
        REG_TAG    = 3'd4
    } reg_idx_t;

    function automatic logic [63:0] lane_word(input ctr_t blk, input logic lane);
        lane_word = lane ? {blk[3], blk[2]} : {blk[1], blk[0]};
    endfunction

endpackage

`default_nettype wire

FILE: design/philox_keyed_random_stream.sv
// Top level of the Philox keyed random stream: register port, sequencer and caches.
// Depends on pkrs_pkg and instantiates the shared round unit pkrs_round.
`default_nettype none

// A draw that hits the cached block passes from acceptance through the result
// state to the output register. A draw that needs a new block runs the shared
// round unit once per cycle for ROUNDS rounds (ten by default), then passes
// through the result state to the output register; the first draw after a change
// of seed, domain, identifier or tag first runs ROUNDS more rounds deriving the
// stream key through the same unit. Seek and unused opcodes finish in their
// accept cycle. The input is not ready while an item is in work; a finished
// beat waits in the output register while the next item is accepted.
module philox_keyed_random_stream
    import pkrs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: opcode (2), index (64), zero padding (6).
    input  wire logic [IN_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // Fields from bit 0: word (64).
    output logic [63:0]            m_tdata,
    // Fields from bit 0: status (1).
    output logic                   m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_BLK,
        ST_RESULT
    } state_t;

    state_t            state_reg;
    logic [63:0]       seed_reg;
    logic [31:0]       domain_reg;
    logic [63:0]       stable_reg;
    logic [63:0]       occur_reg;
    logic [31:0]       tag_reg;
    logic [63:0]       dkey_reg;
    logic              key_ready_reg;
    ctr_t              cache_reg;
    logic [62:0]       cache_num_reg;
    logic              cache_ready_reg;
    logic [63:0]       next_draw_reg;
    logic              ood_reg;
    ctr_t              ctr_reg;
    logic [63:0]       key_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [62:0]       blk_reg;
    logic              lane_reg;
    logic              seq_reg;
    logic [63:0]       res_word_reg;
    logic              res_status_reg;
    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic              m_tuser_reg;

    ctr_t              ctr_next;
    logic [63:0]       key_next;
    logic              cfg_wr;
    logic [IDX_W-1:0]  cfg_idx;
    logic              in_acc;
    logic [1:0]        in_op;
    logic [63:0]       in_idx;
    logic              last_rnd;

    pkrs_round u_round (
        .ctr      (ctr_reg),
        .key      (key_reg),
        .ctr_next (ctr_next),
        .key_next (key_next)
    );

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign in_op    = s_tdata[1:0];
    assign in_idx   = s_tdata[65:2];
    assign last_rnd = (rnd_reg == RND_W'(ROUNDS - 1));
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb
    begin
        case (cfg_idx)
            REG_SEED:   prdata = seed_reg;
            REG_DOMAIN: prdata = {32'd0, domain_reg};
            REG_STABLE: prdata = stable_reg;
            REG_OCCUR:  prdata = occur_reg;
            REG_TAG:    prdata = {32'd0, tag_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seed_reg        <= '0;
            domain_reg      <= '0;
            stable_reg      <= '0;
            occur_reg       <= '0;
            tag_reg         <= '0;
            dkey_reg        <= '0;
            key_ready_reg   <= 1'b0;
            cache_reg       <= '0;
            cache_num_reg   <= '0;
            cache_ready_reg <= 1'b0;
            next_draw_reg   <= '0;
            ood_reg         <= 1'b0;
            ctr_reg         <= '0;
            key_reg         <= '0;
            rnd_reg         <= '0;
            blk_reg         <= '0;
            lane_reg        <= 1'b0;
            seq_reg         <= 1'b0;
            res_word_reg    <= '0;
            res_status_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            m_tdata_reg     <= '0;
            m_tuser_reg     <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr && (cfg_idx <= REG_TAG))
            begin
                next_draw_reg   <= '0;
                ood_reg         <= 1'b0;
                cache_ready_reg <= 1'b0;
                cache_num_reg   <= '0;
                case (cfg_idx)
                    REG_SEED:
                    begin
                        seed_reg      <= pwdata;
                        key_ready_reg <= 1'b0;
                    end
                    REG_DOMAIN:
                    begin
                        domain_reg    <= pwdata[31:0];
                        key_ready_reg <= 1'b0;
                    end
                    REG_STABLE:
                    begin
                        stable_reg    <= pwdata;
                        key_ready_reg <= 1'b0;
                    end
                    REG_OCCUR:
                    begin
                        occur_reg <= pwdata;
                    end
                    REG_TAG:
                    begin
                        tag_reg       <= pwdata[31:0];
                        key_ready_reg <= 1'b0;
                    end
                    default:
                    begin
                        occur_reg <= occur_reg;
                    end
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        rnd_reg <= '0;
                        case (in_op)
                            OP_NEXT:
                            begin
                                if (ood_reg)
                                begin
                                    res_word_reg   <= '0;
                                    res_status_reg <= 1'b1;
                                    state_reg      <= ST_RESULT;
                                end
                                else
                                begin
                                    blk_reg  <= next_draw_reg[63:1];
                                    lane_reg <= next_draw_reg[0];
                                    seq_reg  <= 1'b1;
                                    res_status_reg <= 1'b0;
                                    if (&next_draw_reg)
                                    begin
                                        ood_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        next_draw_reg <= next_draw_reg + 64'd1;
                                    end
                                    if (cache_ready_reg &&
                                        (cache_num_reg == next_draw_reg[63:1]))
                                    begin
                                        res_word_reg <= lane_word(cache_reg,
                                                                  next_draw_reg[0]);
                                        state_reg    <= ST_RESULT;
                                    end
                                    else if (key_ready_reg)
                                    begin
                                        ctr_reg   <= {1'b0, next_draw_reg[63:33],
                                                      next_draw_reg[32:1],
                                                      occur_reg[63:32], occur_reg[31:0]};
                                        key_reg   <= dkey_reg;
                                        state_reg <= ST_BLK;
                                    end
                                    else
                                    begin
                                        ctr_reg   <= {stable_reg[63:32], stable_reg[31:0],
                                                      domain_reg, tag_reg};
                                        key_reg   <= seed_reg;
                                        state_reg <= ST_KEY;
                                    end
                                end
                            end
                            OP_AT:
                            begin
                                blk_reg        <= in_idx[63:1];
                                lane_reg       <= in_idx[0];
                                seq_reg        <= 1'b0;
                                res_status_reg <= 1'b0;
                                if (key_ready_reg)
                                begin
                                    ctr_reg   <= {1'b0, in_idx[63:33], in_idx[32:1],
                                                  occur_reg[63:32], occur_reg[31:0]};
                                    key_reg   <= dkey_reg;
                                    state_reg <= ST_BLK;
                                end
                                else
                                begin
                                    ctr_reg   <= {stable_reg[63:32], stable_reg[31:0],
                                                  domain_reg, tag_reg};
                                    key_reg   <= seed_reg;
                                    state_reg <= ST_KEY;
                                end
                            end
                            OP_SEEK:
                            begin
                                next_draw_reg <= in_idx;
                                ood_reg       <= 1'b0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_KEY:
                begin
                    if (last_rnd)
                    begin
                        dkey_reg      <= {ctr_next[1], ctr_next[0]};
                        key_ready_reg <= 1'b1;
                        key_reg       <= {ctr_next[1], ctr_next[0]};
                        ctr_reg       <= {1'b0, blk_reg[62:32], blk_reg[31:0],
                                          occur_reg[63:32], occur_reg[31:0]};
                        rnd_reg       <= '0;
                        state_reg     <= ST_BLK;
                    end
                    else
                    begin
                        rnd_reg <= rnd_reg + RND_W'(1);
                        ctr_reg <= ctr_next;
                        key_reg <= key_next;
                    end
                end
                ST_BLK:
                begin
                    rnd_reg <= rnd_reg + RND_W'(1);
                    ctr_reg <= ctr_next;
                    key_reg <= key_next;
                    if (last_rnd)
                    begin
                        res_word_reg <= lane_word(ctr_next, lane_reg);
                        if (seq_reg)
                        begin
                            cache_reg       <= ctr_next;
                            cache_num_reg   <= blk_reg;
                            cache_ready_reg <= 1'b1;
                        end
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_word_reg;
                        m_tuser_reg  <= res_status_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: design/pkrs_round.sv
// One Philox4x32 round with its key schedule step, purely combinational.
// Depends on pkrs_pkg for the multiplier and Weyl constants.
`default_nettype none

module pkrs_round
    import pkrs_pkg::*;
(
    input  wire ctr_t        ctr,
    input  wire logic [63:0] key,
    output ctr_t             ctr_next,
    output logic [63:0]      key_next
);

    logic [63:0] p0;
    logic [63:0] p1;

    assign p0 = {32'd0, PH_M0} * {32'd0, ctr[0]};
    assign p1 = {32'd0, PH_M1} * {32'd0, ctr[2]};

    assign ctr_next[0] = p1[63:32] ^ ctr[1] ^ key[31:0];
    assign ctr_next[1] = p1[31:0];
    assign ctr_next[2] = p0[63:32] ^ ctr[3] ^ key[63:32];
    assign ctr_next[3] = p0[31:0];

    assign key_next = {key[63:32] + PH_W1, key[31:0] + PH_W0};

endmodule

`default_nettype wire

FILE: design/pkrs_checker.sv
// Port-level checks for the Philox keyed random stream, bound to its top level.
// Depends on pkrs_pkg for the opcode codes and the input beat width.
`default_nettype none

module pkrs_checker
    import pkrs_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            s_tvalid,
    input wire logic            s_tready,
    input wire logic [IN_W-1:0] s_tdata,
    input wire logic            m_tvalid,
    input wire logic            m_tready,
    input wire logic [63:0]     m_tdata,
    input wire logic            m_tuser
);

    // A stalled result beat keeps its content.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

    // An exhausted draw always carries a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
    else $error("exhausted beat with nonzero word");

    // A draw that yields a result leaves the input not ready in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] == OP_NEXT || s_tdata[1:0] == OP_AT)
        |=> !s_tready)
    else $error("input ready right after a draw was accepted");

    // A new result beat appears only after the input side was held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result beat without a draw in work");

endmodule

bind philox_keyed_random_stream pkrs_checker u_checker (.*);

`default_nettype wire
